// ===== rtl/ppo_pkg.sv =====
// Shared types, opcodes and constants of the pixel point operation unit.
package ppo_pkg;

	// Opcodes carried with each pixel. Codes 6 and 7 pass the pixel through.
	typedef enum logic [2:0] {
		OP_BRIGHTEN = 3'd0,
		OP_DARKEN   = 3'd1,
		OP_CONTRAST = 3'd2,
		OP_NEGATIVE = 3'd3,
		OP_GRAY     = 3'd4,
		OP_QUANT    = 3'd5
	} ppo_op_t;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 12;
	localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_GAIN   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_LEVELS = 2'd2;

	localparam int OFFSET_W = 9;
	localparam int GAIN_W   = 12;
	localparam int LEVELS_W = 9;
	localparam int STEP_W   = 9;
	localparam int RECIP_W  = 17;
	localparam int CHAN_W   = 8;
	localparam int LANES    = 3;

	// Reset values; four levels give a step of 64.
	localparam logic signed [OFFSET_W-1:0] OFFSET_RST = 9'sd0;
	localparam logic signed [GAIN_W-1:0]   GAIN_RST   = 12'sd256;
	localparam logic [STEP_W-1:0]          STEP_RST   = 9'd64;
	localparam logic [RECIP_W-1:0]         RECIP_RST  = 17'd1024;

	// Q16 luma weights; they add up to exactly 65536.
	localparam logic [23:0] LUMA_R = 24'd19595;
	localparam logic [23:0] LUMA_G = 24'd38470;
	localparam logic [23:0] LUMA_B = 24'd7471;

	// Pipeline advance enables handed from the top level to the datapath.
	typedef struct packed {
		logic en_s1;
		logic en_s2;
	} ppo_pipe_ctl_t;

	typedef logic [255:0][STEP_W-1:0]  step_tab_t;
	typedef logic [255:0][RECIP_W-1:0] recip_tab_t;

	function automatic logic [CHAN_W-1:0] clamp_u8(input logic signed [10:0] v);
		logic [CHAN_W-1:0] r;
		if (v[10]) begin
			r = 8'd0;
		end else if (v[9:8] != 2'b00) begin
			r = 8'd255;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/ppo_lane.sv =====
// One channel lane: brighten, darken, contrast, negative and quantize for a single color.
module ppo_lane (
	input  logic                                  clk,
	input  ppo_pkg::ppo_pipe_ctl_t                ctl,
	input  logic [ppo_pkg::CHAN_W-1:0]            chan,
	input  ppo_pkg::ppo_op_t                      op_s1,
	input  logic signed [ppo_pkg::OFFSET_W-1:0]   offset,
	input  logic signed [ppo_pkg::GAIN_W-1:0]     gain,
	input  logic [ppo_pkg::STEP_W-1:0]            step,
	input  logic [ppo_pkg::RECIP_W-1:0]           recip,
	output logic [ppo_pkg::CHAN_W-1:0]            result
);
	import ppo_pkg::*;

	logic [CHAN_W-1:0]        c_s1;
	logic signed [19:0]       con_s1;
	logic [24:0]              qprod_s1;
	logic signed [7:0]        centered;

	logic signed [10:0]       c_ext;
	logic signed [10:0]       off_ext;
	logic signed [10:0]       bright;
	logic signed [10:0]       dark;
	logic signed [21:0]       con_sum;
	logic [CHAN_W-1:0]        con_res;
	logic [8:0]               quot;
	logic [17:0]              base;
	logic [9:0]               quant_sum;
	logic [CHAN_W-1:0]        quant_res;

	// The channel minus 128 is the channel with its top bit flipped.
	assign centered = {~chan[7], chan[6:0]};

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			c_s1     <= chan;
			con_s1   <= 20'(centered) * 20'(gain);
			qprod_s1 <= 25'(chan) * 25'(recip);
		end
	end

	always_comb begin
		c_ext   = $signed({3'b000, c_s1});
		off_ext = {{2{offset[OFFSET_W-1]}}, offset};
		bright  = c_ext + off_ext;
		dark    = c_ext - off_ext;

		con_sum = {{2{con_s1[19]}}, con_s1} + 22'sd32768;
		if (con_sum[21]) begin
			con_res = 8'd0;
		end else if (con_sum[20:16] != 5'd0) begin
			con_res = 8'd255;
		end else begin
			con_res = con_sum[15:8];
		end

		quot      = qprod_s1[24:16];
		base      = 18'(quot) * 18'(step);
		quant_sum = base[9:0] + {2'b00, step[STEP_W-1:1]};
		quant_res = (quant_sum > 10'd255) ? 8'd255 : quant_sum[7:0];

		case (op_s1)
			OP_BRIGHTEN: result = clamp_u8(bright);
			OP_DARKEN:   result = clamp_u8(dark);
			OP_CONTRAST: result = con_res;
			OP_NEGATIVE: result = ~c_s1;
			OP_QUANT:    result = quant_res;
			default:     result = c_s1;
		endcase
	end

endmodule

// ===== rtl/ppo_merge.sv =====
// Merge stage: luma from all three channels, and the output register of the processed pixel.
module ppo_merge (
	input  logic                                      clk,
	input  ppo_pkg::ppo_pipe_ctl_t                    ctl,
	input  logic [ppo_pkg::CHAN_W-1:0]                blue_in,
	input  logic [ppo_pkg::CHAN_W-1:0]                green_in,
	input  logic [ppo_pkg::CHAN_W-1:0]                red_in,
	input  ppo_pkg::ppo_op_t                          op_s1,
	input  logic [ppo_pkg::LANES-1:0][ppo_pkg::CHAN_W-1:0] lane_res,
	output logic [ppo_pkg::CHAN_W-1:0]                blue_out,
	output logic [ppo_pkg::CHAN_W-1:0]                green_out,
	output logic [ppo_pkg::CHAN_W-1:0]                red_out
);
	import ppo_pkg::*;

	logic [23:0]       luma_b_s1;
	logic [23:0]       luma_g_s1;
	logic [23:0]       luma_r_s1;
	logic [23:0]       luma_sum;
	logic [CHAN_W-1:0] y;

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			luma_b_s1 <= 24'(blue_in) * LUMA_B;
			luma_g_s1 <= 24'(green_in) * LUMA_G;
			luma_r_s1 <= 24'(red_in) * LUMA_R;
		end
	end

	// The weights sum to 65536, so the total never exceeds 24 bits.
	assign luma_sum = luma_b_s1 + luma_g_s1 + luma_r_s1;
	assign y        = luma_sum[23:16];

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			if (op_s1 == OP_GRAY) begin
				blue_out  <= y;
				green_out <= y;
				red_out   <= y;
			end else begin
				blue_out  <= lane_res[0];
				green_out <= lane_res[1];
				red_out   <= lane_res[2];
			end
		end
	end

endmodule

// ===== rtl/pixel_point_operation_unit_top.sv =====
// Top level of the pixel point operation unit: handshake, configuration and three lanes.
//
// Usage: a pixel (opcode plus blue, green and red bytes) enters on the request channel
// (req_valid/req_ready); the processed pixel leaves on the response channel
// (rsp_valid/rsp_ready). A transaction completes on a rising edge where valid and ready
// are both high. Every pixel gives exactly one result, in order.
// A taken pixel passes through the stage one and stage two registers; rsp_valid is
// high while stage two holds it. Throughput is one pixel per clock while the receiver
// does not stall: stage one holds the products (contrast gain, quantization
// reciprocal, luma weights), stage two the saturated result. The quantization multiply
// feeding the second multiply of the same lane sets the two-stage depth.
// When the receiver stalls, the output stage holds its pixel and stage one can still
// take one more pixel, so req_ready only drops once both stages are full.
// The configuration port (cfg_we, cfg_index, cfg_wdata) writes a register:
// index 0 brightness offset, 1 contrast gain, 2 quantization levels; index 3 is ignored.
// The levels register is stored as its step and reciprocal, looked up at write time.
// Asynchronous reset empties the pipeline and loads offset 0, unity gain and four levels.
module pixel_point_operation_unit_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_ready,
	input  logic [2:0]                           opcode,
	input  logic [ppo_pkg::CHAN_W-1:0]           blue_in,
	input  logic [ppo_pkg::CHAN_W-1:0]           green_in,
	input  logic [ppo_pkg::CHAN_W-1:0]           red_in,
	output logic                                 rsp_valid,
	input  logic                                 rsp_ready,
	output logic [ppo_pkg::CHAN_W-1:0]           blue_out,
	output logic [ppo_pkg::CHAN_W-1:0]           green_out,
	output logic [ppo_pkg::CHAN_W-1:0]           red_out,
	input  logic                                 cfg_we,
	input  logic [ppo_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [ppo_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
	import ppo_pkg::*;

	ppo_pipe_ctl_t                   ctl;
	logic                            valid_s1;
	logic                            valid_s2;
	ppo_op_t                         op_s1;

	logic signed [OFFSET_W-1:0]      offset_q;
	logic signed [GAIN_W-1:0]        gain_q;
	logic [STEP_W-1:0]               step_q;
	logic [RECIP_W-1:0]              recip_q;

	logic [LEVELS_W-1:0]             levels;
	logic [LEVELS_W-1:0]             levels_m1;
	logic [7:0]                      level_idx;
	step_tab_t                       step_tab;
	recip_tab_t                      recip_tab;

	logic [LANES-1:0][CHAN_W-1:0]    lane_in;
	logic [LANES-1:0][CHAN_W-1:0]    lane_res;

	// Stage two advances when it is empty or its pixel is taken; stage one when it is
	// empty or stage two can receive.
	assign ctl.en_s2 = !valid_s2 || rsp_ready;
	assign ctl.en_s1 = !valid_s1 || ctl.en_s2;
	assign req_ready = ctl.en_s1;
	assign rsp_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ctl.en_s1) begin
				valid_s1 <= req_valid;
			end
			if (ctl.en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			op_s1 <= ppo_op_t'(opcode);
		end
	end

	// Constant tables indexed by levels minus one: the step, and ceil(65536 / step).
	// With an 8-bit dividend and a step of at most 256, (c * recip) >> 16 gives the
	// exact quotient.
	for (genvar i = 0; i < 256; i++) begin : g_level
		localparam int STEP_V  = 256 / (i + 1);
		localparam int RECIP_V = (65536 + STEP_V - 1) / STEP_V;
		assign step_tab[i]  = STEP_W'(STEP_V);
		assign recip_tab[i] = RECIP_W'(RECIP_V);
	end

	// Only the low nine bits of the written value count; zero levels behave as one level and 256 to 511 as 256 levels.
	assign levels    = cfg_wdata[LEVELS_W-1:0];
	assign levels_m1 = levels - 9'd1;
	always_comb begin
		if (levels == 9'd0) begin
			level_idx = 8'd0;
		end else if (levels[LEVELS_W-1]) begin
			level_idx = 8'd255;
		end else begin
			level_idx = levels_m1[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RST;
			gain_q   <= GAIN_RST;
			step_q   <= STEP_RST;
			recip_q  <= RECIP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OFFSET: offset_q <= $signed(cfg_wdata[OFFSET_W-1:0]);
				CFG_GAIN:   gain_q   <= $signed(cfg_wdata[GAIN_W-1:0]);
				CFG_LEVELS: begin
					step_q  <= step_tab[level_idx];
					recip_q <= recip_tab[level_idx];
				end
				default: ;
			endcase
		end
	end

	// Lane 0 is blue, lane 1 green, lane 2 red.
	assign lane_in[0] = blue_in;
	assign lane_in[1] = green_in;
	assign lane_in[2] = red_in;

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		ppo_lane u_lane (
			.clk    (clk),
			.ctl    (ctl),
			.chan   (lane_in[g]),
			.op_s1  (op_s1),
			.offset (offset_q),
			.gain   (gain_q),
			.step   (step_q),
			.recip  (recip_q),
			.result (lane_res[g])
		);
	end

	ppo_merge u_merge (
		.clk       (clk),
		.ctl       (ctl),
		.blue_in   (blue_in),
		.green_in  (green_in),
		.red_in    (red_in),
		.op_s1     (op_s1),
		.lane_res  (lane_res),
		.blue_out  (blue_out),
		.green_out (green_out),
		.red_out   (red_out)
	);

endmodule
